// ===== design/checked_int64_alu_assert.svh =====
// assertion macros for the checked 64-bit arithmetic unit
`ifndef CHECKED_INT64_ALU_ASSERT_SVH
`define CHECKED_INT64_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define CIA_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CIA_ASSERT_IMP(label, clk, rstn, a, c)
`define CIA_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

// ===== design/cia_pkg.sv =====
// package with operation and status codes of the checked arithmetic unit
package cia_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    localparam int unsigned DW = 64;
    localparam int unsigned STAGES = DW + 4;

    typedef struct packed {
        op_t              op;
        logic             neg;
        status_t          st;
        logic [DW-1:0]    res;
        logic [DW-1:0]    rem;
        logic [DW-1:0]    quo;
        logic [DW-1:0]    dvs;
        logic [2*DW-1:0]  acc;
    } lane_t;
endpackage

// ===== design/checked_int64_alu.sv =====
// checked 64-bit add, subtract, multiply and divide unit
// usage:
//   s_ side takes a beat (s_req_type, s_operand_a, s_operand_b) when
//   s_valid and s_ready are both high; m_ side gives (m_value, m_status)
//   under m_valid / m_ready
//   every operation runs through the same pipeline of 68 stages:
//   one stage of sign and magnitude preparation, 64 stages of restoring
//   division (one quotient bit each), two stages that only carry the beat
//   and a final stage that settles sign, overflow and the result;
//   multiplication uses four 32x32 partial-product steps in the first
//   division stages
//   m_valid rises once an accepted beat reaches the final stage; one beat
//   is accepted every cycle while the output side takes results
//   the division chain, one bit a stage, sets the depth
//   when the receiver stalls the whole pipeline holds, s_ready falls
//   only while the last stage holds a beat that is not taken; nothing
//   is lost or repeated
//   reset (aresetn low at a clock edge) clears all valid bits; payload
//   registers keep their contents
module checked_int64_alu (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic signed [63:0]   s_operand_a,
    input  logic signed [63:0]   s_operand_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [63:0]   m_value,
    output logic [1:0]           m_status
);
    import cia_pkg::*;
    `include "checked_int64_alu_assert.svh"

    logic [STAGES-1:0] vld_reg;
    lane_t             lane_reg [STAGES];
    lane_t             lane_next [STAGES];
    logic              adv;

    assign adv     = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[STAGES-1];
    assign m_value = lane_reg[STAGES-1].res;
    assign m_status = lane_reg[STAGES-1].st;

    // entry stage: add/sub, magnitudes, special divide cases
    logic [DW-1:0] a_u, b_u, ma, mb, sum, dif;
    always_comb begin
        a_u = s_operand_a;
        b_u = s_operand_b;
        ma  = a_u[DW-1] ? (~a_u + 1'b1) : a_u;
        mb  = b_u[DW-1] ? (~b_u + 1'b1) : b_u;
        sum = a_u + b_u;
        dif = a_u - b_u;
        lane_next[0]     = '0;
        lane_next[0].op  = op_t'(s_req_type);
        lane_next[0].neg = a_u[DW-1] ^ b_u[DW-1];
        lane_next[0].rem = ma;
        lane_next[0].dvs = mb;
        lane_next[0].st  = ST_OK;
        case (op_t'(s_req_type))
            OP_ADD: begin
                lane_next[0].res = sum;
                if (a_u[DW-1] == b_u[DW-1] && sum[DW-1] != a_u[DW-1])
                    lane_next[0].st = ST_OVF;
            end
            OP_SUB: begin
                lane_next[0].res = dif;
                if (a_u[DW-1] != b_u[DW-1] && dif[DW-1] != a_u[DW-1])
                    lane_next[0].st = ST_OVF;
            end
            OP_MUL: begin
                lane_next[0].quo = mb;
            end
            OP_DIV: begin
                if (b_u == '0)
                    lane_next[0].st = ST_DIVZ;
                else if (a_u == {1'b1, {(DW-1){1'b0}}} && b_u == '1)
                    lane_next[0].st = ST_OVF;
            end
            default: ;
        endcase
    end

    // middle stages: stages 1..64 give one quotient bit each; multiply uses stages 1..4
    for (genvar g = 1; g < STAGES - 1; g++) begin : g_stage
        always_comb begin
            logic [DW:0]   trial;
            logic [DW:0]   shifted;
            logic [DW/2-1:0] xa, yb;
            logic [DW-1:0] pp;
            lane_next[g] = lane_reg[g-1];
            shifted = '0;
            trial = '0;
            xa = '0;
            yb = '0;
            pp = '0;
            if (g <= DW && lane_reg[g-1].op == OP_DIV) begin
                // partial remainder in acc shifts in dividend bits from rem
                shifted = {lane_reg[g-1].acc[DW-1:0], lane_reg[g-1].rem[DW-1]};
                trial   = shifted - {1'b0, lane_reg[g-1].dvs};
                lane_next[g].rem = {lane_reg[g-1].rem[DW-2:0], 1'b0};
                if (!trial[DW]) begin
                    lane_next[g].acc = {{DW{1'b0}}, trial[DW-1:0]};
                    lane_next[g].quo = {lane_reg[g-1].quo[DW-2:0], 1'b1};
                end else begin
                    lane_next[g].acc = {{DW{1'b0}}, shifted[DW-1:0]};
                    lane_next[g].quo = {lane_reg[g-1].quo[DW-2:0], 1'b0};
                end
            end else if (g <= 4 && lane_reg[g-1].op == OP_MUL) begin
                xa = ((g - 1) / 2 == 0) ? lane_reg[g-1].rem[DW/2-1:0]
                                        : lane_reg[g-1].rem[DW-1:DW/2];
                yb = ((g - 1) % 2 == 0) ? lane_reg[g-1].dvs[DW/2-1:0]
                                        : lane_reg[g-1].dvs[DW-1:DW/2];
                pp = {{(DW/2){1'b0}}, xa} * {{(DW/2){1'b0}}, yb};
                lane_next[g].acc = lane_reg[g-1].acc +
                    ({{DW{1'b0}}, pp} << (((g - 1) / 2 + (g - 1) % 2) * (DW/2)));
            end
        end
    end

    // final stage: sign, multiply overflow, result forced to zero on error
    always_comb begin
        lane_t p;
        logic [DW-1:0] lo, hi;
        p  = lane_reg[STAGES-2];
        lo = p.acc[DW-1:0];
        hi = p.acc[2*DW-1:DW];
        lane_next[STAGES-1] = p;
        case (p.op)
            OP_MUL: begin
                if (p.neg) begin
                    if (hi != '0 || lo > {1'b1, {(DW-1){1'b0}}})
                        lane_next[STAGES-1].st = ST_OVF;
                    else
                        lane_next[STAGES-1].res = ~lo + 1'b1;
                end else begin
                    if (hi != '0 || lo[DW-1])
                        lane_next[STAGES-1].st = ST_OVF;
                    else
                        lane_next[STAGES-1].res = lo;
                end
            end
            OP_DIV: begin
                lane_next[STAGES-1].res = p.neg ? (~p.quo + 1'b1) : p.quo;
            end
            default: ;
        endcase
        if (lane_next[STAGES-1].st != ST_OK)
            lane_next[STAGES-1].res = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < STAGES; i++)
                lane_reg[i] <= lane_next[i];
        end
    end

    `CIA_ASSERT_IMP(a_zero_on_err, aclk, aresetn, m_valid && m_status != ST_OK, m_value == '0)
    `CIA_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status != 2'd3)
    `CIA_ASSERT_NXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_status))
    `CIA_ASSERT_IMP(a_ready_rule, aclk, aresetn, !s_ready, m_valid && !m_ready)
endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the checked 64-bit arithmetic unit
module tb_top;
    import cia_pkg::*;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } alu_result_t;

    class result_board;
        alu_result_t pending[$];
        int          errors;

        function alu_result_t compute(op_t op, logic [63:0] a, logic [63:0] b);
            alu_result_t r;
            logic signed [127:0] wide;
            logic signed [64:0]  sum;
            r.value  = '0;
            r.status = ST_OK;
            case (op)
                OP_ADD: begin
                    sum = $signed({a[63], a}) + $signed({b[63], b});
                    if (sum[64] != sum[63]) r.status = ST_OVF;
                    else r.value = sum[63:0];
                end
                OP_SUB: begin
                    sum = $signed({a[63], a}) - $signed({b[63], b});
                    if (sum[64] != sum[63]) r.status = ST_OVF;
                    else r.value = sum[63:0];
                end
                OP_MUL: begin
                    wide = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                    if (wide[127:63] != {65{wide[63]}}) r.status = ST_OVF;
                    else r.value = wide[63:0];
                end
                default: begin
                    if (b == '0) r.status = ST_DIVZ;
                    else if (a == MIN64 && b == '1) r.status = ST_OVF;
                    else r.value = $signed(a) / $signed(b);
                end
            endcase
            return r;
        endfunction

        function void note_request(op_t op, logic [63:0] a, logic [63:0] b);
            pending.push_back(compute(op, a, b));
        endfunction

        function void check_result(logic [63:0] value, logic [1:0] status);
            alu_result_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat value=%h status=%0d", value, status);
                return;
            end
            e = pending.pop_front();
            if (value !== e.value || status !== e.status) begin
                errors++;
                if (errors <= 10)
                    $display("expected value=%h status=%0d, got value=%h status=%0d",
                             e.value, e.status, value, status);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [63:0] s_operand_a = '0;
    logic [63:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_value;
    logic [1:0]  m_status;

    int src_idle = 0;
    int sink_stall = 0;
    result_board board = new();

    checked_int64_alu DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value), .m_status(m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_request(op_t'(s_req_type), s_operand_a, s_operand_b);
            if (m_valid && m_ready) board.check_result(m_value, m_status);
            m_ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return MIN64;
            1: return MAX64;
            2: return '0;
            3: return '1;
            4: return {$urandom, $urandom};
            5: return {{32{$urandom_range(1) == 1}}, 32'($urandom)};
            6: return 64'($signed(32'($urandom_range(20)) - 10));
            default: return {{48{$urandom_range(1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    task automatic send_beat(op_t op, logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        op_t ops[4];
        int  n;
        ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (ops[i]) begin
            send_beat(ops[i], MAX64, MAX64);
            send_beat(ops[i], MIN64, MIN64);
            send_beat(ops[i], MIN64, '1);
            send_beat(ops[i], MAX64, '0);
            send_beat(ops[i], MIN64, 64'd1);
        end
        send_beat(OP_DIV, '0, '0);
        send_beat(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
        send_beat(OP_MUL, 64'hffff_ffff_0000_0000, 64'h0000_0000_8000_0000);
        send_beat(OP_DIV, -64'sd7, 64'sd2);
        for (int ph = 0; ph < 4; ph++) begin
            src_idle   = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 51) : 0;
            sink_stall = (ph == 2) ? 51 : ((ph == 3) ? 24 : 0);
            n = 350;
            repeat (n) send_beat(op_t'($urandom_range(3)), pick_operand(), pick_operand());
        end
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (board.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/cia_pkg.sv
design/checked_int64_alu.sv
tb/sv/tb_top.sv
